// ----- hw/rtl/htc_pkg.sv -----
// Package for the hit time clustering block: field widths, constants,
// the cluster record type, the divider request and response types, and the sequencer states.
// Used by htc_divider and hit_time_clustering; depends on nothing else.
`default_nettype none

package htc_pkg;

	localparam int TimeW   = 16;
	localparam int SizeW   = 24;
	localparam int TsumW   = 22;
	localparam int CountW  = 7;
	localparam int MergedW = 6;

	// The divider retires one quotient bit per cycle.
	localparam int DivSteps = TsumW;
	localparam int StepW    = $clog2(DivSteps);

	localparam logic [SizeW-1:0] SizeMax        = '1;
	localparam logic [TimeW-1:0] ThresholdReset = 16'd160;

	// One finished cluster that is waiting for its mean time.
	typedef struct packed {
		logic [TsumW-1:0]  time_sum;
		logic [SizeW-1:0]  size_sum;
		logic [CountW-1:0] count;
		logic              last;
	} htc_slot_t;

	typedef struct packed {
		logic              start;
		logic [TsumW-1:0]  dividend;
		logic [CountW-1:0] divisor;
	} htc_div_req_t;

	typedef struct packed {
		logic             done;
		logic [TsumW-1:0] quotient;
	} htc_div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} htc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/htc_divider.sv -----
// Restoring divider for the cluster mean: time sum over hit count, one bit per cycle.
// Depends on htc_pkg for widths and the request and response types.
`default_nettype none

module htc_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  htc_pkg::htc_div_req_t req,
	output htc_pkg::htc_div_rsp_t rsp
);
	import htc_pkg::*;

	localparam logic [StepW-1:0] StepLast = StepW'(DivSteps - 1);

	logic [TsumW-1:0]  dvd_q;
	logic [CountW-1:0] rem_q;
	logic [CountW-1:0] dvs_q;
	logic [StepW-1:0]  step_q;
	logic              busy_q;
	logic              done_q;

	logic [CountW:0] rem_shift;
	logic [CountW:0] rem_diff;
	logic            rem_ge;

	// The partial remainder stays below the divisor, so the shifted value fits CountW+1 bits.
	always_comb begin
		rem_shift = {rem_q, dvd_q[TsumW-1]};
		rem_ge    = rem_shift >= {1'b0, dvs_q};
		rem_diff  = rem_shift - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == StepLast) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Quotient bits shift in at the bottom as dividend bits leave at the top.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TsumW-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[CountW-1:0] : rem_shift[CountW-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hit_time_clustering.sv -----
// Top level of the hit time clustering block: accumulator, result queue and sequencer.
// Depends on htc_pkg and on htc_divider for the cluster mean.
`default_nettype none

// Hits of one channel arrive in time order, one per transfer. A hit joins the
// open cluster when its distance from the previous hit is below merge_threshold
// and the cluster holds fewer than MAX_RUN hits; otherwise the open cluster is
// closed and the hit starts a new one. A hit with tlast set also closes the
// cluster that it ends up in, so one hit can close up to two clusters. Every
// closed cluster is reported with its truncated mean time, saturated size sum
// and merged hit count. Each closed cluster is queued when the hit is taken,
// then launched into the shared restoring divider that forms the mean; the
// sequencer sees the divider finish and moves the result into the output
// register, waiting while a stalled output register drains. A hit that only
// merges is taken without further work. The input is ready only while the
// sequencer is idle, but a result may still wait in the output register
// meanwhile. merge_threshold is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle, since the block itself
// does not enforce this.

module hit_time_clustering #(
	parameter int MAX_RUN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: merge_threshold.
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// Hit input. s_tdata: hit_time [15:0], hit_size [39:16].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tlast,   // last_hit
	// Cluster output. m_tdata: cluster_time [15:0], cluster_size [39:16],
	// merged_count [45:40], zero [47:46].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tlast    // last_cluster
);
	import htc_pkg::*;

	localparam logic [CountW-1:0] MaxRunC = CountW'(MAX_RUN);

	// Configuration register.
	logic [TimeW-1:0] threshold_q;

	// Open cluster.
	logic [TsumW-1:0]  time_sum_q;
	logic [SizeW-1:0]  size_sum_q;
	logic [CountW-1:0] hit_count_q;
	logic [TimeW-1:0]  prev_time_q;
	logic              open_q;

	// Queue of closed clusters waiting for the divider: slot A is served first.
	htc_slot_t  slot_a_q;
	htc_slot_t  slot_b_q;
	logic [1:0] pend_n_q;

	htc_state_t state_q;
	logic       div_go_q;

	// Output register.
	logic               m_tvalid_q;
	logic [TimeW-1:0]   out_time_q;
	logic [SizeW-1:0]   out_size_q;
	logic [MergedW-1:0] out_merged_q;
	logic               out_last_q;

	htc_div_req_t div_req;
	htc_div_rsp_t div_rsp;

	logic [TimeW-1:0]  in_time;
	logic [SizeW-1:0]  in_size;
	logic              in_last;
	logic              accept;
	logic [TimeW-1:0]  gap;
	logic              do_merge;
	logic              emit_old;
	logic [SizeW:0]    size_add;
	logic [SizeW-1:0]  size_sat;
	htc_slot_t         old_cl;
	htc_slot_t         new_cl;
	logic              out_load;
	logic [CountW-1:0] merged_full;

	assign in_time  = s_tdata[TimeW-1:0];
	assign in_size  = s_tdata[TimeW+SizeW-1:TimeW];
	assign in_last  = s_tlast;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Merge decision and the cluster as it stands after this hit.
	always_comb begin
		gap      = (in_time >= prev_time_q) ? (in_time - prev_time_q) : (prev_time_q - in_time);
		do_merge = open_q && (gap < threshold_q) && (hit_count_q < MaxRunC);
		emit_old = open_q && !do_merge;
		size_add = {1'b0, size_sum_q} + {1'b0, in_size};
		size_sat = size_add[SizeW] ? SizeMax : size_add[SizeW-1:0];

		old_cl.time_sum = time_sum_q;
		old_cl.size_sum = size_sum_q;
		old_cl.count    = hit_count_q;
		old_cl.last     = 1'b0;

		if (do_merge) begin
			new_cl.time_sum = time_sum_q + TsumW'(in_time);
			new_cl.size_sum = size_sat;
			new_cl.count    = hit_count_q + 1'b1;
		end else begin
			new_cl.time_sum = TsumW'(in_time);
			new_cl.size_sum = in_size;
			new_cl.count    = CountW'(1);
		end
		new_cl.last = 1'b1;
	end

	assign out_load    = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
	assign merged_full = slot_a_q.count - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ThresholdReset;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// Cluster accumulator. A flush leaves no cluster open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_sum_q  <= '0;
			size_sum_q  <= '0;
			hit_count_q <= '0;
			prev_time_q <= '0;
			open_q      <= 1'b0;
		end else if (accept) begin
			prev_time_q <= in_time;
			if (in_last) begin
				time_sum_q  <= '0;
				size_sum_q  <= '0;
				hit_count_q <= '0;
				open_q      <= 1'b0;
			end else begin
				time_sum_q  <= new_cl.time_sum;
				size_sum_q  <= new_cl.size_sum;
				hit_count_q <= new_cl.count;
				open_q      <= 1'b1;
			end
		end
	end

	// The older cluster always goes first, so the flushed one comes out second.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (emit_old) begin
				slot_a_q <= old_cl;
				slot_b_q <= new_cl;
			end else begin
				slot_a_q <= new_cl;
			end
		end else if (out_load) begin
			slot_a_q <= slot_b_q;
		end
	end

	// Sequencer: launch the divider, wait for the mean, hand the result over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pend_n_q <= '0;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (emit_old || in_last)) begin
						pend_n_q <= (emit_old && in_last) ? 2'd2 : 2'd1;
						div_go_q <= 1'b1;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						pend_n_q <= pend_n_q - 1'b1;
						if (pend_n_q == 2'd2) begin
							div_go_q <= 1'b1;
							state_q  <= S_DIV;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign div_req.start    = div_go_q;
	assign div_req.dividend = slot_a_q.time_sum;
	assign div_req.divisor  = slot_a_q.count;

	htc_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// The mean never exceeds the largest hit time, so the low bits are the whole quotient.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_time_q   <= div_rsp.quotient[TimeW-1:0];
			out_size_q   <= slot_a_q.size_sum;
			out_merged_q <= merged_full[MergedW-1:0];
			out_last_q   <= slot_a_q.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_merged_q, out_size_q, out_time_q};
	assign m_tlast  = out_last_q;

	// A new hit is only taken once every closed cluster has been handed over.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> pend_n_q == 2'd0)
		else $error("input ready while clusters are still queued");

	// The divider finishes only while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	// The flushed cluster is always the final one of its hit.
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && slot_a_q.last) |=> pend_n_q == 2'd0)
		else $error("cluster queued behind the flushed cluster");

	// An open cluster never grows beyond the run limit.
	a_run_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hit_count_q <= MaxRunC)
		else $error("cluster exceeds the run limit");

endmodule

`default_nettype wire
